FILE: src/rfalu_pkg.sv
// Package for the register file ALU executor: operation codes, widths, defaults.
// No dependencies.
package rfalu_pkg;

    localparam int DefRegCount  = 32;
    localparam int DefDataWidth = 64;
    localparam int IdxW         = 5;
    localparam int ImmW         = 32;
    localparam int OutW         = 64;

    typedef enum logic [3:0] {
        OP_IN   = 4'd0,
        OP_OUT  = 4'd1,
        OP_MOV  = 4'd2,
        OP_XCHG = 4'd3,
        OP_ADD  = 4'd4,
        OP_SUB  = 4'd5,
        OP_MUL  = 4'd6,
        OP_DIV  = 4'd7,
        OP_MOD  = 4'd8,
        OP_AND  = 4'd9,
        OP_OR   = 4'd10,
        OP_XOR  = 4'd11
    } op_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture request, read operands
        logic exec;     // non-iterative ops / divider and multiplier setup
        logic div_step; // one restoring step
        logic mul_step; // partial product step
        logic commit;   // write back, form result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_div;
        logic is_mul;
        logic div_last;
        logic mul_last;
    } dp_stat_t;

endpackage

FILE: src/rfalu_if.sv
// Valid/ready channel interfaces for the executor.
// No dependencies.
interface rfalu_req_if;
    logic                  valid;
    logic                  ready;
    logic [3:0]            mode;
    logic [4:0]            dest;
    logic [4:0]            src_a;
    logic [4:0]            src_b;
    logic                  three_operand;
    logic signed [31:0]    immediate;
    modport source (output valid, mode, dest, src_a, src_b, three_operand, immediate,
                    input ready);
    modport sink   (input valid, mode, dest, src_a, src_b, three_operand, immediate,
                    output ready);
endinterface

interface rfalu_rsp_if;
    logic               valid;
    logic               ready;
    logic               out_valid;
    logic signed [63:0] out_value;
    logic               div_zero;
    modport source (output valid, out_valid, out_value, div_zero, input ready);
    modport sink   (input valid, out_valid, out_value, div_zero, output ready);
endinterface

FILE: src/register_file_alu_executor.sv
// Register file ALU executor: one request in, one response out.
// Accept to response valid: load, execute, then NCH (data width / 16) multiplier steps for MUL
// or DATA_WIDTH divider steps for DIV/MOD (the bit-serial divider sets the worst case), then WB, RSP.
// One request at a time: the next request enters as the response leaves.
// Reset: rst_n async low; all registers read as zero, no response pending.
module register_file_alu_executor
#(
    parameter int REG_COUNT  = rfalu_pkg::DefRegCount,
    parameter int DATA_WIDTH = rfalu_pkg::DefDataWidth
)
(
    input  logic  clk,
    input  logic  rst_n,
    rfalu_req_if.sink   req,
    rfalu_rsp_if.source rsp
);
    import rfalu_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // controller: IDLE -> EXEC -> (DIV | MUL iterations) -> WB -> RSP
    rfalu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // datapath captures the request on cmd.load, response held in registers
    rfalu_dp #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (req.mode),
        .dest          (req.dest),
        .src_a         (req.src_a),
        .src_b         (req.src_b),
        .three_operand (req.three_operand),
        .immediate     (req.immediate),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (rsp.out_valid),
        .out_value     (rsp.out_value),
        .div_zero      (rsp.div_zero)
    );

endmodule

FILE: src/rfalu_ctrl.sv
// Controller FSM for the executor: sequences load, execute, iterate, commit.
// Depends on rfalu_pkg.
module rfalu_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output rfalu_pkg::dp_cmd_t  cmd,
    input  rfalu_pkg::dp_stat_t stat
);
    import rfalu_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_DIV  = 6'b000100,
        S_MUL  = 6'b001000,
        S_WB   = 6'b010000,
        S_RSP  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        rsp_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.is_div)
                    state_next = S_DIV;
                else if (stat.is_mul)
                    state_next = S_MUL;
                else
                    state_next = S_WB;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                    state_next = S_WB;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (stat.mul_last)
                    state_next = S_WB;
            end
            S_WB:
            begin
                cmd.commit = 1'b1;
                state_next = S_RSP;
            end
            S_RSP:
            begin
                rsp_valid = 1'b1;
                // output register frees the datapath; next request can enter
                in_ready  = rsp_ready;
                if (rsp_ready)
                begin
                    if (in_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = S_EXEC;
                    end
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

FILE: src/rfalu_dp.sv
// Datapath: register file, ALU, 16x16-chunk multiplier, restoring divider.
// Depends on rfalu_pkg.
module rfalu_dp
#(
    parameter int REG_COUNT  = rfalu_pkg::DefRegCount,
    parameter int DATA_WIDTH = rfalu_pkg::DefDataWidth
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [3:0]                 mode,
    input  logic [rfalu_pkg::IdxW-1:0] dest,
    input  logic [rfalu_pkg::IdxW-1:0] src_a,
    input  logic [rfalu_pkg::IdxW-1:0] src_b,
    input  logic                       three_operand,
    input  logic [rfalu_pkg::ImmW-1:0] immediate,
    input  rfalu_pkg::dp_cmd_t         cmd,
    output rfalu_pkg::dp_stat_t        stat,
    output logic                       out_valid,
    output logic [rfalu_pkg::OutW-1:0] out_value,
    output logic                       div_zero
);
    import rfalu_pkg::*;

    localparam int AW   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int W    = DATA_WIDTH;
    localparam int CW   = $clog2(W + 1);
    localparam int MC   = 16;                 // multiplier chunk width
    localparam int NCH  = (W + MC - 1) / MC;  // chunks of the multiplier
    localparam int MCW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int PW   = NCH * MC;

    // registers with valid bits cleared at reset; invalid reads as zero
    logic [W-1:0]         rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;

    logic [3:0]   op_reg;
    logic [AW-1:0] d_reg, a_reg;
    logic [W-1:0] x_reg, y_reg, rd_reg, ra_reg, imm_reg;
    logic [W-1:0] res_reg;
    logic         wr_reg, dz_reg;

    // divider
    logic [W-1:0] quo_reg, rem_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic         negq_reg, negr_reg;
    // multiplier
    logic [PW-1:0] acc_reg, mcand_reg;
    logic [MCW-1:0] mcnt_reg;

    logic         out_valid_reg, div_zero_reg;
    logic [OutW-1:0] out_value_reg;

    // index wraps modulo REG_COUNT (for REG_COUNT >= 2) by up to (1 << IdxW) / 2 subtracts
    function automatic logic [AW-1:0] idx(input logic [IdxW-1:0] f);
        int t;
        t = int'(f);
        for (int k = 0; k < (1 << IdxW) / 2; k++)
            if (t >= REG_COUNT)
                t = t - REG_COUNT;
        return AW'(t);
    endfunction

    function automatic logic [W-1:0] rd(input logic [W-1:0] v,
                                       input logic vl);
        return vl ? v : '0;
    endfunction

    logic [AW-1:0] di, ai, bi, xi, yi;
    always_comb
    begin
        di = idx(dest);
        ai = idx(src_a);
        bi = idx(src_b);
        xi = three_operand ? ai : di;
        yi = three_operand ? bi : ai;
    end

    logic [W-1:0] ma, mb, rem_sh, rem_sub;
    logic         ge;
    always_comb
    begin
        ma      = x_reg[W-1] ? W'(-x_reg) : x_reg;
        mb      = y_reg[W-1] ? W'(-y_reg) : y_reg;
        rem_sh  = {rem_reg[W-2:0], quo_reg[W-1]};
        ge      = (rem_reg[W-1] == 1'b1) || (rem_sh >= dvs_reg);
        rem_sub = rem_sh - dvs_reg;
    end

    // y chunk for multiply step
    logic [PW-1:0] ypad;
    logic [MC-1:0] ych;
    always_comb
    begin
        ypad = PW'(y_reg);
        ych  = ypad[mcnt_reg*MC +: MC];
    end
    // mcand holds x shifted by the step; the row is x times one chunk of y
    logic [PW-1:0] row;
    always_comb
    begin
        row = '0;
        for (int k = 0; k < NCH; k++)
            row = row + (PW'(mcand_reg[k*MC +: MC] * ych) << (k*MC));
    end

    assign stat.is_div   = (op_reg == OP_DIV || op_reg == OP_MOD) && (y_reg != '0);
    assign stat.is_mul   = (op_reg == OP_MUL);
    assign stat.div_last = (cnt_reg == CW'(1));
    assign stat.mul_last = (mcnt_reg == MCW'(NCH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg    <= '0;
            out_valid_reg <= 1'b0;
            div_zero_reg  <= 1'b0;
            out_value_reg <= '0;
        end
        else if (cmd.commit)
        begin
            if (wr_reg)
                rf_vld_reg <= rf_vld_reg | (REG_COUNT'(1) << d_reg)
                              | ((op_reg == OP_XCHG) ? (REG_COUNT'(1) << a_reg) : '0);
            out_valid_reg <= (op_reg == OP_OUT);
            div_zero_reg  <= dz_reg;
            out_value_reg <= (op_reg == OP_OUT) ? OutW'($signed(rd_reg)) : '0;
        end
    end

    // XCHG writes both registers; dest wins when they are the same
    always_ff @(posedge clk)
    begin
        if (cmd.commit && wr_reg)
        begin
            for (int k = 0; k < REG_COUNT; k++)
            begin
                if (AW'(k) == d_reg)
                    rf_mem[k] <= res_reg;
                else if (op_reg == OP_XCHG && AW'(k) == a_reg)
                    rf_mem[k] <= rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= mode;
            d_reg   <= di;
            a_reg   <= ai;
            x_reg   <= rd(rf_mem[xi], rf_vld_reg[xi]);
            y_reg   <= rd(rf_mem[yi], rf_vld_reg[yi]);
            rd_reg  <= rd(rf_mem[di], rf_vld_reg[di]);
            ra_reg  <= rd(rf_mem[ai], rf_vld_reg[ai]);
            imm_reg <= W'({{(OutW-ImmW){immediate[ImmW-1]}}, immediate});
        end
        if (cmd.exec)
        begin
            wr_reg   <= 1'b1;
            dz_reg   <= 1'b0;
            quo_reg  <= ma;
            rem_reg  <= '0;
            dvs_reg  <= mb;
            cnt_reg  <= CW'(W);
            negq_reg <= x_reg[W-1] ^ y_reg[W-1];
            negr_reg <= x_reg[W-1];
            acc_reg  <= '0;
            mcand_reg <= PW'(x_reg);
            mcnt_reg <= '0;
            case (op_reg)
                OP_IN:   res_reg <= imm_reg;
                OP_OUT:  wr_reg  <= 1'b0;
                OP_MOV:  res_reg <= ra_reg;
                OP_XCHG: res_reg <= ra_reg;
                OP_ADD:  res_reg <= x_reg + y_reg;
                OP_SUB:  res_reg <= x_reg - y_reg;
                OP_AND:  res_reg <= x_reg & y_reg;
                OP_OR:   res_reg <= x_reg | y_reg;
                OP_XOR:  res_reg <= x_reg ^ y_reg;
                OP_MUL:  res_reg <= '0;
                OP_DIV, OP_MOD:
                begin
                    if (y_reg == '0)
                    begin
                        wr_reg <= 1'b0;
                        dz_reg <= 1'b1;
                    end
                end
                default: wr_reg <= 1'b0;
            endcase
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            rem_reg <= ge ? rem_sub : rem_sh;
            quo_reg <= {quo_reg[W-2:0], ge};
            if (cnt_reg == CW'(1))
            begin
                if (op_reg == OP_DIV)
                    res_reg <= negq_reg ? W'(-{quo_reg[W-2:0], ge}) : {quo_reg[W-2:0], ge};
                else
                    res_reg <= negr_reg ? W'(-(ge ? rem_sub : rem_sh))
                                        : (ge ? rem_sub : rem_sh);
            end
        end
        if (cmd.mul_step)
        begin
            mcnt_reg  <= mcnt_reg + MCW'(1);
            mcand_reg <= mcand_reg << MC;
            acc_reg   <= acc_reg + row;
            if (mcnt_reg == MCW'(NCH - 1))
                res_reg <= W'(acc_reg + row);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;
    assign div_zero  = div_zero_reg;

endmodule

FILE: src/rfalu_chk.sv
// Port checker for the executor, bound to the top level.
// Depends on the channel interfaces.
module rfalu_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic        out_valid,
    input logic [63:0] out_value,
    input logic        div_zero
);
    // no new request while a response is held and not taken
    a_no_req_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |-> !req_ready)
        else $error("request taken during response stall");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(out_value)))
        else $error("response dropped");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(out_valid && div_zero))
        else $error("out and div_zero together");

    a_zero_val: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !out_valid) |-> (out_value == 64'd0))
        else $error("nonzero value without out");

    // no response in the cycle right after a request is taken
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !rsp_valid)
        else $error("response too early");

endmodule

bind register_file_alu_executor rfalu_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .out_valid (rsp.out_valid),
    .out_value (rsp.out_value),
    .div_zero  (rsp.div_zero)
);

FILE: tb/sv/rfalu_tb_if.sv
// Small parameter bundle shared by the testbench modules.
// Depends on nothing; the RTL interfaces in src/rfalu_if.sv are used directly.
package rfalu_tb_pkg;

    localparam int TbRegCount  = 32;
    localparam int TbDataWidth = 64;
    localparam int SettleCycles = 80;

endpackage

FILE: tb/sv/register_file_alu_executor_chk.sv
// Checker for the register file ALU executor: watches both channels, predicts, compares.
// Depends on rfalu_pkg, rfalu_tb_pkg and the rfalu_req_if / rfalu_rsp_if interfaces.
module register_file_alu_executor_chk
    import rfalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rfalu_req_if        req,
    rfalu_rsp_if        rsp,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        out_valid;
        logic [63:0] out_value;
        logic        div_zero;
    } outcome_t;

    logic [63:0] regs [rfalu_tb_pkg::TbRegCount];
    outcome_t    expected_q [$];

    function automatic logic [63:0] sdiv_quot(logic [63:0] x, logic [63:0] y, bit want_rem);
        logic [63:0] ma, mb, q;
        ma = x[63] ? -x : x;
        mb = y[63] ? -y : y;
        if (want_rem)
        begin
            q = ma % mb;
            return x[63] ? -q : q;
        end
        q = ma / mb;
        return (x[63] ^ y[63]) ? -q : q;
    endfunction

    task automatic execute(input logic [3:0] mode, input logic [4:0] d, input logic [4:0] a,
                           input logic [4:0] b, input logic three, input logic [31:0] imm);
        logic [63:0] x, y, r;
        bit          wr;
        outcome_t    o;
        o  = '0;
        wr = 1'b1;
        r  = '0;
        x  = three ? regs[a] : regs[d];
        y  = three ? regs[b] : regs[a];
        case (mode)
            OP_IN:   r = {{32{imm[31]}}, imm};
            OP_OUT:
            begin
                o.out_valid = 1'b1;
                o.out_value = regs[d];
                wr = 1'b0;
            end
            OP_MOV:  r = regs[a];
            OP_XCHG:
            begin
                r = regs[a];
                regs[a] = regs[d];
            end
            OP_ADD:  r = x + y;
            OP_SUB:  r = x - y;
            OP_MUL:  r = x * y;
            OP_DIV, OP_MOD:
            begin
                if (y == 0)
                begin
                    o.div_zero = 1'b1;
                    wr = 1'b0;
                end
                else
                    r = sdiv_quot(x, y, mode == OP_MOD);
            end
            OP_AND:  r = x & y;
            OP_OR:   r = x | y;
            OP_XOR:  r = x ^ y;
            default: wr = 1'b0;
        endcase
        if (wr)
            regs[d] = r;
        expected_q.push_back(o);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t e;
        if (!rst_n)
        begin
            foreach (regs[k]) regs[k] = '0;
            expected_q.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
                execute(req.mode, req.dest, req.src_a, req.src_b, req.three_operand,
                        req.immediate);
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: response with nothing expected", $realtime);
                    errors <= errors + 1;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (e.out_valid !== rsp.out_valid || e.out_value !== rsp.out_value
                        || e.div_zero !== rsp.div_zero)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch exp v=%b val=%h dz=%b got v=%b val=%h dz=%b",
                                     $realtime, e.out_valid, e.out_value, e.div_zero,
                                     rsp.out_valid, rsp.out_value, rsp.div_zero);
                        errors <= errors + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

FILE: tb/sv/register_file_alu_executor_tb.sv
// Testbench top for the register file ALU executor: clock, reset, stimulus and verdict.
// Depends on rfalu_pkg, rfalu_tb_pkg, the channel interfaces and the checker module.
module register_file_alu_executor_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rfalu_pkg::*;

    localparam int RandomRequests = 600;
    localparam int CycleLimit     = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   cycles = 0;
    bit   stall_long = 1'b0;   // receiver hold-off window, set by its own process
    bit   stim_done = 1'b0;

    rfalu_req_if req ();
    rfalu_rsp_if rsp ();

    register_file_alu_executor i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    register_file_alu_executor_chk i_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .errors  (errors),
        .pending (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Known values from time zero.
    initial
    begin
        req.valid = 1'b0;
        req.mode = '0;
        req.dest = '0;
        req.src_a = '0;
        req.src_b = '0;
        req.three_operand = 1'b0;
        req.immediate = '0;
        rsp.ready = 1'b0;
    end

    // Watchdog: also the only place a timeout verdict is given.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("FAIL register_file_alu_executor");
            $finish;
        end
    end

    // Extreme-ish immediates: mix of corners and random values.
    function automatic logic [31:0] pick_imm();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return 32'd1;
            5: return $urandom_range(0, 15);
            default: return $urandom();
        endcase
    endfunction

    // Drive one request, hold it until accepted, then draw an idle gap.
    task automatic send(input logic [3:0] mode, input logic [4:0] d, input logic [4:0] a,
                        input logic [4:0] b, input logic three, input logic [31:0] imm,
                        input bit gaps);
        int gap;
        req.valid <= 1'b1;
        req.mode <= mode;
        req.dest <= d;
        req.src_a <= a;
        req.src_b <= b;
        req.three_operand <= three;
        req.immediate <= imm;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Receiver: random ready gaps per response, plus the long hold-off window.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clk);
            while (stall_long)
                @(posedge clk);
            rsp.ready <= 1'b1;
            @(posedge clk);
            while (!rsp.valid)
                @(posedge clk);
        end
    end

    // Long hold-off: counted in its own process while requests keep coming.
    initial
    begin
        @(posedge rst_n);
        repeat (2000) @(posedge clk);
        stall_long = 1'b1;
        repeat (400) @(posedge clk);
        stall_long = 1'b0;
    end

    initial
    begin
        logic [3:0] m;
        bit         gaps;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: load corners, every op, div by zero, zero / -1, an unused mode.
        send(OP_IN, 5'd1, 5'd0, 5'd0, 1'b0, 32'h8000_0000, 1'b1);
        send(OP_IN, 5'd2, 5'd0, 5'd0, 1'b1, 32'hFFFF_FFFF, 1'b1);
        send(OP_IN, 5'd3, 5'd0, 5'd0, 1'b0, 32'h7FFF_FFFF, 1'b1);
        send(OP_MUL, 5'd1, 5'd3, 5'd0, 1'b0, '0, 1'b0);       // build a large negative
        send(OP_MUL, 5'd1, 5'd3, 5'd0, 1'b0, '0, 1'b0);
        send(OP_OUT, 5'd1, 5'd0, 5'd0, 1'b0, '0, 1'b0);
        send(OP_IN, 5'd4, 5'd0, 5'd0, 1'b0, 32'd1, 1'b0);
        send(OP_SUB, 5'd5, 5'd0, 5'd4, 1'b1, '0, 1'b0);       // r5 = 0 - 1
        send(OP_SUB, 5'd6, 5'd5, 5'd3, 1'b1, '0, 1'b0);
        send(OP_SUB, 5'd6, 5'd3, 5'd0, 1'b1, '0, 1'b0);
        send(OP_IN, 5'd7, 5'd0, 5'd0, 1'b0, 32'h8000_0000, 1'b0);
        send(OP_MUL, 5'd7, 5'd7, 5'd7, 1'b1, '0, 1'b0);      // 2^62
        send(OP_ADD, 5'd7, 5'd7, 5'd0, 1'b0, '0, 1'b0);
        send(OP_ADD, 5'd7, 5'd7, 5'd0, 1'b0, '0, 1'b0);      // min + min wraps to zero
        send(OP_DIV, 5'd8, 5'd7, 5'd5, 1'b1, '0, 1'b0);      // zero / -1
        send(OP_MOD, 5'd9, 5'd7, 5'd5, 1'b1, '0, 1'b0);
        send(OP_DIV, 5'd8, 5'd0, 5'd0, 1'b0, '0, 1'b0);      // divide by zero
        send(OP_MOD, 5'd9, 5'd1, 5'd0, 1'b1, '0, 1'b0);
        send(OP_XCHG, 5'd8, 5'd1, 5'd0, 1'b1, '0, 1'b0);
        send(OP_XCHG, 5'd8, 5'd8, 5'd0, 1'b0, '0, 1'b0);     // exchange with itself
        send(OP_MOV, 5'd31, 5'd8, 5'd0, 1'b1, '0, 1'b0);
        send(OP_AND, 5'd31, 5'd5, 5'd0, 1'b0, '0, 1'b0);
        send(OP_OR, 5'd30, 5'd1, 5'd7, 1'b1, '0, 1'b0);
        send(OP_XOR, 5'd30, 5'd5, 5'd0, 1'b0, '0, 1'b0);
        send(4'd15, 5'd31, 5'd31, 5'd31, 1'b1, 32'hFFFF_FFFF, 1'b0);
        send(OP_OUT, 5'd31, 5'd0, 5'd0, 1'b0, '0, 1'b0);
        send(OP_OUT, 5'd30, 5'd0, 5'd0, 1'b1, '0, 1'b0);

        // Random: stretches with and without idling.
        for (int n = 0; n < RandomRequests; n++)
        begin
            gaps = ((n / 50) % 3) != 2;
            case ($urandom_range(0, 9))
                0, 1: m = OP_IN;
                2:    m = OP_OUT;
                3:    m = 4'($urandom_range(12, 15));
                default: m = 4'($urandom_range(0, 11));
            endcase
            send(m, 5'($urandom()), 5'($urandom()), 5'($urandom()), 1'($urandom()),
                 pick_imm(), gaps);
        end
        req.valid <= 1'b0;

        // the checker's count is registered, so wait before reading it
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (rfalu_tb_pkg::SettleCycles) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS register_file_alu_executor");
        else
            $display("FAIL register_file_alu_executor");
        $finish;
    end

endmodule
